/* rtl/mslw_pkg.sv */
// Shared types and constants for the multi-slot liveness watchdog.
package mslw_pkg;

    localparam int SLOTS       = 8;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MISS_W      = 8;
    localparam int IDX_W       = 8;
    localparam int ID_W        = 3;
    localparam int CMD_W       = 2;

    typedef logic [COUNT_WIDTH-1:0] t_beat;
    typedef logic [MISS_W-1:0]      t_miss;
    typedef logic [SLOT_W-1:0]      t_slot;

    typedef enum logic [CMD_W-1:0] {
        CMD_CLAIM  = 2'd0,
        CMD_KICK   = 2'd1,
        CMD_ENABLE = 2'd2,
        CMD_CHECK  = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    // Result of one slot evaluation
    typedef struct packed {
        logic  dead;
        t_miss miss_next;
    } t_eval;

    // Walk control from the sequencer to the slot storage
    typedef struct packed {
        logic  active;
        t_slot ptr;
        logic  upd_miss;
        logic  finish;
        logic  alive;
    } t_walk_ctl;

endpackage

/* rtl/mslw_eval.sv */
// Shared slot evaluation unit: beat increment, limit compare, miss update.
module mslw_eval
    import mslw_pkg::*;
(
    input  t_beat i_beat,
    input  t_beat i_snap,
    input  t_miss i_miss,
    input  t_miss i_limit,
    output t_beat o_beat_inc,
    output t_eval o_eval
);

    t_miss miss_sat;

    assign o_beat_inc = i_beat + t_beat'(1);
    assign miss_sat   = (i_miss == '1) ? i_miss : i_miss + t_miss'(1);

    always_comb begin
        o_eval.dead      = (i_miss >= i_limit);
        o_eval.miss_next = (i_beat == i_snap) ? miss_sat : '0;
    end

endmodule

/* rtl/mslw_seq.sv */
// Check sequencer: walks the slot pointer and tracks the first failure.
module mslw_seq
    import mslw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_go,
    input  logic      i_in_use,
    input  logic      i_dead,
    output t_walk_ctl o_ctl
);

    t_state r_state, n_state;
    t_slot  r_ptr,   n_ptr;
    logic   r_failed, n_failed;
    logic   hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ptr    <= '0;
            r_failed <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_failed <= n_failed;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_failed = r_failed;
        hit      = i_in_use && i_dead;

        o_ctl.active   = 1'b0;
        o_ctl.ptr      = r_ptr;
        o_ctl.upd_miss = 1'b0;
        o_ctl.finish   = 1'b0;
        o_ctl.alive    = !(r_failed || hit);

        case (r_state)
            ST_IDLE: begin
                if (i_go) begin
                    n_state  = ST_WALK;
                    n_ptr    = '0;
                    n_failed = 1'b0;
                end
            end
            ST_WALK: begin
                o_ctl.active   = 1'b1;
                // misses stop updating from the first dead slot on
                o_ctl.upd_miss = i_in_use && !r_failed && !i_dead;
                n_failed       = r_failed || hit;
                if (r_ptr == t_slot'(SLOTS - 1)) begin
                    o_ctl.finish = 1'b1;
                    n_state      = ST_IDLE;
                    n_ptr        = '0;
                end else begin
                    n_ptr = r_ptr + t_slot'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/multi_slot_liveness_watchdog.sv */
// Top level of the multi-slot liveness watchdog: slot storage, command decode, results.
//
// Watchdog over SLOTS client slots. A command is taken when start is high and
// busy is low; its single result appears on the o_ ports for one cycle with
// o_strobe high, and the receiver must take it then. Claim, kick and enable
// finish directly: the result shows on the next cycle and busy never rises,
// so a new command can be issued every cycle. A check walks the slots one per
// cycle through the shared evaluation unit, so busy is high for the whole walk,
// and the result strobes on the cycle busy drops; a new command may be
// issued in that same cycle. The miss limit register is written through the
// i_cfg channel, which is always ready; write it only while no command is
// outstanding. Claim with no free slot returns slot 0; kick or enable with an
// index of SLOTS or more changes nothing and flags o_index_error.
module multi_slot_liveness_watchdog
    import mslw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // command channel
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [IDX_W-1:0]  i_slot_index,
    input  logic              i_enable,
    // results
    output logic              o_strobe,
    output logic [ID_W-1:0]   o_slot_id,
    output logic              o_index_error,
    output logic              o_all_alive,
    // miss limit register
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MISS_W-1:0] i_cfg_data
);

    // slot state
    logic  r_in_use [SLOTS];
    t_beat r_beat   [SLOTS];
    t_beat r_snap   [SLOTS];
    t_miss r_miss   [SLOTS];
    t_miss r_miss_limit;

    // result registers
    logic            r_strobe;
    logic [ID_W-1:0] r_slot_id;
    logic            r_index_error;
    logic            r_all_alive;

    t_cmd      cmd;
    logic      accept;
    logic      in_range;
    t_slot     addr;
    t_slot     free_slot;
    logic      free_found;
    t_beat     beat_inc;
    t_eval     eval;
    t_walk_ctl ctl;

    assign cmd         = t_cmd'(i_cmd);
    assign busy        = ctl.active;
    assign accept      = start && !busy;
    assign in_range    = (i_slot_index < IDX_W'(SLOTS));
    assign o_cfg_ready = 1'b1;

    // one read port: the walk pointer during a check, the command index otherwise
    assign addr = ctl.active ? ctl.ptr : i_slot_index[SLOT_W-1:0];

    // lowest free slot for claim
    always_comb begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int s = SLOTS - 1; s >= 0; s--) begin
            if (!r_in_use[s]) begin
                free_slot  = t_slot'(s);
                free_found = 1'b1;
            end
        end
    end

    mslw_eval u_eval (
        .i_beat     (r_beat[addr]),
        .i_snap     (r_snap[addr]),
        .i_miss     (r_miss[addr]),
        .i_limit    (r_miss_limit),
        .o_beat_inc (beat_inc),
        .o_eval     (eval)
    );

    mslw_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (accept && (cmd == CMD_CHECK)),
        .i_in_use (r_in_use[addr]),
        .i_dead   (eval.dead),
        .o_ctl    (ctl)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_limit <= MISS_W'(3);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_miss_limit <= i_cfg_data;
        end
    end

    // slot storage updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                r_in_use[s] <= 1'b0;
                r_beat[s]   <= '0;
                r_snap[s]   <= '0;
                r_miss[s]   <= '0;
            end
        end else if (ctl.active) begin
            r_snap[ctl.ptr] <= r_beat[ctl.ptr];
            if (ctl.upd_miss) begin
                r_miss[ctl.ptr] <= eval.miss_next;
            end
        end else if (accept) begin
            case (cmd)
                CMD_CLAIM: begin
                    if (free_found) begin
                        r_in_use[free_slot] <= 1'b1;
                        r_beat[free_slot]   <= '0;
                        r_miss[free_slot]   <= '0;
                    end
                end
                CMD_KICK: begin
                    if (in_range) begin
                        r_beat[addr] <= beat_inc;
                    end
                end
                CMD_ENABLE: begin
                    if (in_range) begin
                        r_in_use[addr] <= i_enable;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= ctl.finish || (accept && (cmd != CMD_CHECK));
        end
    end

    // result fields
    always_ff @(posedge i_clk) begin
        if (ctl.finish) begin
            r_slot_id     <= '0;
            r_index_error <= 1'b0;
            r_all_alive   <= ctl.alive;
        end else begin
            r_slot_id     <= '0;
            r_index_error <= 1'b0;
            r_all_alive   <= 1'b0;
            case (cmd)
                CMD_CLAIM: begin
                    r_slot_id <= free_found ? ID_W'(free_slot) : '0;
                end
                CMD_KICK, CMD_ENABLE: begin
                    r_index_error <= !in_range;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_strobe      = r_strobe;
    assign o_slot_id     = r_slot_id;
    assign o_index_error = r_index_error;
    assign o_all_alive   = r_all_alive;

endmodule

/* rtl/mslw_chk.sv */
// Port-level checker for the multi-slot liveness watchdog, bound to the top level.
module mslw_chk
    import mslw_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [CMD_W-1:0]  i_cmd,
    input logic              o_strobe,
    input logic [ID_W-1:0]   o_slot_id,
    input logic              o_index_error,
    input logic              o_all_alive
);

    // claim, kick and enable commands answer on the next cycle
    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd != CMD_CHECK) |=> o_strobe && !busy)
        else $error("single-cycle command without result");

    // a check holds the block busy
    a_check_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_cmd == CMD_CHECK) |=> busy && !o_strobe)
        else $error("check did not go busy");

    // end of a check always delivers its result
    a_check_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && !o_index_error && (o_slot_id == '0))
        else $error("check finished without result");

    // no result while a walk is in progress
    a_quiet_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy && $past(busy) |-> !o_strobe)
        else $error("result during check walk");

    // an index error carries no grant and no health flag
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_index_error |-> (o_slot_id == '0) && !o_all_alive)
        else $error("index error with other fields set");

endmodule

bind multi_slot_liveness_watchdog mslw_chk u_mslw_chk (.*);
